// ----- hdl/pmba_pkg.sv -----
// Shared types and constants of the proportional memory budget allocator.
package pmba_pkg;

   localparam int BYTE_W = 36;
   localparam int SEG_W  = 21;
   localparam int BUF_W  = 16;
   localparam int SLOT_W = 4;
   localparam int CMD_W  = 3;
   localparam int STAT_W = 2;
   localparam int CSR_W  = 2;

   localparam logic [BYTE_W-1:0] BYTE_MAX = '1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_UNREGISTER = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RESERVE    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REQUEST    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RETURN     = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOMEM    = 2'd1;
   localparam logic [STAT_W-1:0] ST_DISABLED = 2'd2;
   localparam logic [STAT_W-1:0] ST_BUSY     = 2'd3;

   // result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_BUDGET = 1'b1;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_SEGMENT_SIZE = 2'd0;
   localparam logic [CSR_W-1:0] CSR_TOTAL_MEMORY = 2'd1;
   localparam logic [CSR_W-1:0] CSR_DISABLED     = 2'd2;

   localparam logic [SEG_W-1:0]  SEG_RESET   = 21'd32768;
   localparam logic [BYTE_W-1:0] TOTAL_RESET = 36'd67108864;

   // one pool table entry
   typedef struct packed {
      logic [BYTE_W-1:0] req_bytes;
      logic [BYTE_W-1:0] max_bytes;
      logic [BYTE_W-1:0] budget;
   } entry_type;

   // table access controls
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

// ----- hdl/pmba_if.sv -----
// Command and result channel interfaces.
interface pmba_req_if;
   import pmba_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [SLOT_W-1:0]   slot;
   logic [BUF_W-1:0]    required_buffers;
   logic [BUF_W-1:0]    max_buffers;
   logic [BYTE_W-1:0]   amount;
   modport source (output valid, command, slot, required_buffers, max_buffers, amount,
                   input ready);
   modport sink (input valid, command, slot, required_buffers, max_buffers, amount,
                 output ready);
endinterface

interface pmba_rsp_if;
   import pmba_pkg::*;
   logic                valid;
   logic                ready;
   logic                kind;
   logic [SLOT_W-1:0]   pool_index;
   logic [BYTE_W-1:0]   value;
   logic [STAT_W-1:0]   status;
   logic                last;
   modport source (output valid, kind, pool_index, value, status, last, input ready);
   modport sink (input valid, kind, pool_index, value, status, last, output ready);
endinterface

// ----- hdl/pmba_table.sv -----
// Pool table memory: one port, registered read data.
module pmba_table
   import pmba_pkg::*;
#(
   parameter int MAX_POOLS = 16,
   parameter int IDX_W     = 4
) (
   input  logic             clock,
   input  mem_ctl_type      ctl,
   input  logic [IDX_W-1:0] addr,
   input  entry_type        wr_data,
   output entry_type        rd_data
);

   entry_type mem [MAX_POOLS];
   entry_type rd_data_ff;

   // write, and registered read; data holds until the next read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/pmba_muldiv.sv -----
// Sequential floor(a * b / c): 36 shift-add steps, then 36 restoring divide steps.
module pmba_muldiv
   import pmba_pkg::*;
#(
   parameter int CAP_W = 40
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [BYTE_W-1:0] mcand,
   input  logic [CAP_W-1:0]  mplier,
   input  logic [CAP_W-1:0]  divisor,
   output logic              done,
   output logic [BYTE_W-1:0] quot
);

   localparam int PW = BYTE_W + CAP_W;
   localparam logic [5:0] LAST_STEP = 6'(BYTE_W - 1);

   typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} mstate_type;

   mstate_type          state_ff;
   logic [5:0]          cnt_ff;
   logic [BYTE_W-1:0]   a_ff;
   logic [CAP_W-1:0]    b_ff;
   logic [CAP_W-1:0]    c_ff;
   logic [PW-1:0]       prod_ff;
   logic [CAP_W-1:0]    rem_ff;
   logic [BYTE_W-1:0]   low_ff;
   logic [BYTE_W-1:0]   quot_ff;
   logic                done_ff;
   logic [CAP_W:0]      trial;
   logic                fits;
   logic [PW-1:0]       prod_next;

   assign trial     = {rem_ff, low_ff[BYTE_W-1]};
   assign fits      = (trial >= {1'b0, c_ff});
   assign prod_next = (prod_ff << 1) + (a_ff[BYTE_W-1] ? PW'(b_ff) : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            M_IDLE: begin
               if (start) begin
                  a_ff     <= mcand;
                  b_ff     <= mplier;
                  c_ff     <= divisor;
                  prod_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= M_MUL;
               end
            end
            // multiplicand bits taken MSB first
            M_MUL: begin
               prod_ff <= prod_next;
               a_ff    <= a_ff << 1;
               if (cnt_ff == LAST_STEP) begin
                  // hand the finished product to the divider
                  rem_ff   <= prod_next[PW-1:BYTE_W];
                  low_ff   <= prod_next[BYTE_W-1:0];
                  cnt_ff   <= '0;
                  state_ff <= M_DIV;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            M_DIV: begin
               rem_ff  <= fits ? CAP_W'(trial - {1'b0, c_ff}) : trial[CAP_W-1:0];
               low_ff  <= low_ff << 1;
               quot_ff <= {quot_ff[BYTE_W-2:0], fits};
               if (cnt_ff == LAST_STEP) begin
                  done_ff  <= 1'b1;
                  state_ff <= M_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

   // remainder stays below the divisor while dividing
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == M_DIV |-> rem_ff < c_ff)
      else $error("divider remainder out of range");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == M_IDLE)
      else $error("start while busy");

   a_done_src: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(state_ff) == M_DIV)
      else $error("done without divide");

endmodule

// ----- hdl/proportional_memory_budget_allocator.sv -----
// Top level: command sequencer of the proportional memory budget allocator.
// Commands arrive on req_ch (valid/ready); each gives zero or more budget beats
// (kind 1, at most one per pool) and then exactly one status beat with last set.
// Configuration is written through csr_write_en/csr_index/csr_write_data while idle.
// One command is in flight at a time; req_ch.ready is high only when idle.
// Request, return, failed and no-change commands pass S_PREP, S_EXEC and S_STATUS,
// then the status beat is registered and the next command can be taken in S_IDLE.
// Register, unregister and reserve-extra redistribute the spare memory: one walk
//   of the pool table (registered read data) when nothing is spare, else a
//   capacity walk and, if any capacity, a share walk with one pass through the
//   shared 36-step multiplier and 36-step divider per pool with spare capacity.
// Reset clears the pool table valid bits, the reserved and used totals, loads
// available bytes with the reset total and the registers with their defaults.
// Results leave through an output register; while a beat waits with rsp_ch.ready
// low, the sequencer holds in any state that emits a beat until the beat is taken.
module proportional_memory_budget_allocator
   import pmba_pkg::*;
#(
   parameter int MAX_POOLS = 16
) (
   input  logic              clock,
   input  logic              reset,
   pmba_req_if.sink          req_ch,
   pmba_rsp_if.source        rsp_ch,
   input  logic              csr_write_en,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [BYTE_W-1:0] csr_write_data
);

   localparam int IDX_W = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
   localparam int CAP_W = BYTE_W + ((MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 0);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_POOLS - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_EXEC, S_SPARE, S_ZRD, S_ZUSE, S_CRD, S_CUSE,
      S_GIVE, S_PRD, S_PUSE, S_MD, S_PEMIT, S_STATUS
   } state_type;

   state_type          state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [BUF_W-1:0]   reqb_ff, reqb_in;
   logic [BUF_W-1:0]   maxb_ff, maxb_in;
   logic [BYTE_W-1:0]  amount_ff, amount_in;
   logic [BYTE_W-1:0]  rq_ff, rq_in;
   logic [BYTE_W-1:0]  mx_ff, mx_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [BYTE_W-1:0]  reserved_ff, reserved_in;
   logic [BYTE_W-1:0]  avail_ff, avail_in;
   logic [BYTE_W-1:0]  used_ff, used_in;
   logic [MAX_POOLS-1:0] valid_ff, valid_in;
   logic [BYTE_W-1:0]  spare_ff, spare_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [CAP_W-1:0]   parts_ff, parts_in;
   logic [BYTE_W-1:0]  give_ff, give_in;
   logic [BYTE_W-1:0]  given_ff, given_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [SEG_W-1:0]   seg_ff, seg_in;
   logic [BYTE_W-1:0]  total_ff, total_in;
   logic               dis_ff, dis_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]  rsp_pool_ff, rsp_pool_in;
   logic [BYTE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   mem_ctl_type        mem_ctl;
   logic [IDX_W-1:0]   mem_addr;
   entry_type          mem_wdata;
   entry_type          rd;
   logic               md_start, md_done;
   logic [BYTE_W-1:0]  md_quot;

   logic               out_free;
   logic [IDX_W-1:0]   sidx;
   logic               in_range;
   logic [BYTE_W:0]    rq_prod;
   logic [BYTE_W:0]    mx_prod;
   logic [BYTE_W:0]    sum_rq, sum_am;
   logic [BYTE_W-1:0]  rd_e, share_e, spare_c, share, budget;
   logic [BYTE_W:0]    budget_sum;

   pmba_table #(.MAX_POOLS(MAX_POOLS), .IDX_W(IDX_W)) u_table (
      .clock   (clock),
      .ctl     (mem_ctl),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (rd)
   );

   pmba_muldiv #(.CAP_W(CAP_W)) u_muldiv (
      .clock   (clock),
      .reset   (reset),
      .start   (md_start),
      .mcand   (give_ff),
      .mplier  (parts_in),
      .divisor (cap_ff),
      .done    (md_done),
      .quot    (md_quot)
   );

   // shared arithmetic
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign sidx       = IDX_W'(slot_ff);
   assign in_range   = ({28'd0, slot_ff} < 32'(MAX_POOLS));
   assign rq_prod    = (BYTE_W+1)'(reqb_ff) * (BYTE_W+1)'(seg_ff);
   assign mx_prod    = (BYTE_W+1)'(maxb_ff) * (BYTE_W+1)'(seg_ff);
   assign sum_rq     = {1'b0, reserved_ff} + {1'b0, rq_ff};
   assign sum_am     = {1'b0, reserved_ff} + {1'b0, amount_ff};
   assign rd_e       = (rd.max_bytes > rd.req_bytes) ? rd.max_bytes - rd.req_bytes : '0;
   assign share_e    = (rd_e < spare_ff) ? rd_e : spare_ff;
   assign spare_c    = (total_ff > reserved_ff) ? total_ff - reserved_ff : '0;
   assign share      = (md_quot > given_ff) ? md_quot - given_ff : '0;
   assign budget_sum = {1'b0, rd.req_bytes} + {1'b0, share};
   assign budget     = budget_sum[BYTE_W] ? BYTE_MAX : budget_sum[BYTE_W-1:0];

   // sequencer next state
   always_comb begin
      logic [BYTE_W:0] tmp;
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      reqb_in       = reqb_ff;
      maxb_in       = maxb_ff;
      amount_in     = amount_ff;
      rq_in         = rq_ff;
      mx_in         = mx_ff;
      status_in     = status_ff;
      reserved_in   = reserved_ff;
      avail_in      = avail_ff;
      used_in       = used_ff;
      valid_in      = valid_ff;
      spare_in      = spare_ff;
      cap_in        = cap_ff;
      parts_in      = parts_ff;
      give_in       = give_ff;
      given_in      = given_ff;
      idx_in        = idx_ff;
      seg_in        = seg_ff;
      total_in      = total_ff;
      dis_in        = dis_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_pool_in   = rsp_pool_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      mem_ctl       = '0;
      mem_addr      = idx_ff;
      mem_wdata     = '{req_bytes: rd.req_bytes, max_bytes: rd.max_bytes,
                        budget: rd.req_bytes};
      md_start      = 1'b0;
      tmp           = '0;

      // configuration writes
      if (csr_write_en) begin
         case (csr_index)
            CSR_SEGMENT_SIZE: seg_in   = csr_write_data[SEG_W-1:0];
            CSR_TOTAL_MEMORY: total_in = csr_write_data;
            CSR_DISABLED:     dis_in   = csr_write_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in    = req_ch.command;
               slot_in   = req_ch.slot;
               reqb_in   = req_ch.required_buffers;
               maxb_in   = req_ch.max_buffers;
               amount_in = req_ch.amount;
               status_in = ST_OK;
               state_in  = S_PREP;
            end
         end
         S_PREP: begin
            rq_in        = rq_prod[BYTE_W] ? BYTE_MAX : rq_prod[BYTE_W-1:0];
            mx_in        = mx_prod[BYTE_W] ? BYTE_MAX : mx_prod[BYTE_W-1:0];
            mem_ctl.rd_en = 1'b1;
            mem_addr     = sidx;
            state_in     = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_STATUS;
            mem_addr = sidx;
            case (cmd_ff)
               CMD_REGISTER: begin
                  if (dis_ff) begin
                     status_in = ST_DISABLED;
                  end else if (!in_range || valid_ff[sidx]) begin
                     status_in = ST_BUSY;
                  end else if (sum_rq > {1'b0, total_ff}) begin
                     status_in = ST_NOMEM;
                  end else begin
                     reserved_in = sum_rq[BYTE_W] ? BYTE_MAX : sum_rq[BYTE_W-1:0];
                     avail_in    = (avail_ff > rq_ff) ? avail_ff - rq_ff : '0;
                     tmp         = {1'b0, used_ff} + {1'b0, rq_ff};
                     used_in     = tmp[BYTE_W] ? BYTE_MAX : tmp[BYTE_W-1:0];
                     valid_in[sidx] = 1'b1;
                     mem_ctl.wr_en  = 1'b1;
                     mem_wdata   = '{req_bytes: rq_ff, max_bytes: mx_ff, budget: rq_ff};
                     state_in    = S_SPARE;
                  end
               end
               CMD_UNREGISTER: begin
                  if (!in_range) begin
                     status_in = ST_BUSY;
                  end else if (valid_ff[sidx]) begin
                     valid_in[sidx] = 1'b0;
                     reserved_in = (reserved_ff > rd.req_bytes) ?
                                   reserved_ff - rd.req_bytes : '0;
                     state_in    = S_SPARE;
                  end
               end
               CMD_RESERVE: begin
                  if (sum_am > {1'b0, total_ff}) begin
                     status_in = ST_NOMEM;
                  end else begin
                     reserved_in = sum_am[BYTE_W] ? BYTE_MAX : sum_am[BYTE_W-1:0];
                     state_in    = S_SPARE;
                  end
               end
               CMD_REQUEST: begin
                  if (dis_ff) begin
                     status_in = ST_DISABLED;
                  end else if (avail_ff == '0 || avail_ff < amount_ff) begin
                     status_in = ST_NOMEM;
                  end else begin
                     avail_in = avail_ff - amount_ff;
                     tmp      = {1'b0, used_ff} + {1'b0, amount_ff};
                     used_in  = tmp[BYTE_W] ? BYTE_MAX : tmp[BYTE_W-1:0];
                  end
               end
               CMD_RETURN: begin
                  tmp      = {1'b0, avail_ff} + {1'b0, amount_ff};
                  avail_in = tmp[BYTE_W] ? BYTE_MAX : tmp[BYTE_W-1:0];
                  used_in  = (used_ff > amount_ff) ? used_ff - amount_ff : '0;
               end
               default: ;
            endcase
         end
         // start of redistribution
         S_SPARE: begin
            spare_in = spare_c;
            idx_in   = '0;
            cap_in   = '0;
            parts_in = '0;
            given_in = '0;
            state_in = (spare_c == '0) ? S_ZRD : S_CRD;
         end
         // nothing spare: every registered pool falls back to its required bytes
         S_ZRD: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = S_ZUSE;
         end
         S_ZUSE: begin
            if (!valid_ff[idx_ff] || out_free) begin
               if (valid_ff[idx_ff]) begin
                  mem_ctl.wr_en = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_BUDGET;
                  rsp_pool_in   = SLOT_W'(idx_ff);
                  rsp_value_in  = rd.req_bytes;
                  rsp_status_in = ST_OK;
                  rsp_last_in   = 1'b0;
               end
               idx_in   = idx_ff + IDX_W'(1);
               state_in = (idx_ff == LAST_IDX) ? S_STATUS : S_ZRD;
            end
         end
         // first walk: summed capacity
         S_CRD: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = S_CUSE;
         end
         S_CUSE: begin
            if (valid_ff[idx_ff]) begin
               cap_in = cap_ff + CAP_W'(share_e);
            end
            idx_in   = idx_ff + IDX_W'(1);
            state_in = (idx_ff == LAST_IDX) ? S_GIVE : S_CRD;
         end
         S_GIVE: begin
            give_in  = (cap_ff < CAP_W'(spare_ff)) ? BYTE_W'(cap_ff) : spare_ff;
            idx_in   = '0;
            state_in = (cap_ff == '0) ? S_STATUS : S_PRD;
         end
         // second walk: cumulative shares
         S_PRD: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = S_PUSE;
         end
         S_PUSE: begin
            if (valid_ff[idx_ff] && rd_e != '0) begin
               parts_in = parts_ff + CAP_W'(share_e);
               md_start = 1'b1;
               state_in = S_MD;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = (idx_ff == LAST_IDX) ? S_STATUS : S_PRD;
            end
         end
         S_MD: begin
            if (md_done) begin
               state_in = S_PEMIT;
            end
         end
         S_PEMIT: begin
            if (out_free) begin
               mem_ctl.wr_en = 1'b1;
               mem_wdata.budget = budget;
               given_in      = given_ff + share;
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_BUDGET;
               rsp_pool_in   = SLOT_W'(idx_ff);
               rsp_value_in  = budget;
               rsp_status_in = ST_OK;
               rsp_last_in   = 1'b0;
               idx_in        = idx_ff + IDX_W'(1);
               state_in      = (idx_ff == LAST_IDX) ? S_STATUS : S_PRD;
            end
         end
         S_STATUS: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_STATUS;
               rsp_pool_in   = slot_ff;
               rsp_value_in  = avail_ff;
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         reserved_ff  <= '0;
         avail_ff     <= TOTAL_RESET;
         used_ff      <= '0;
         valid_ff     <= '0;
         seg_ff       <= SEG_RESET;
         total_ff     <= TOTAL_RESET;
         dis_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reserved_ff  <= reserved_in;
         avail_ff     <= avail_in;
         used_ff      <= used_in;
         valid_ff     <= valid_in;
         seg_ff       <= seg_in;
         total_ff     <= total_in;
         dis_ff       <= dis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      slot_ff       <= slot_in;
      reqb_ff       <= reqb_in;
      maxb_ff       <= maxb_in;
      amount_ff     <= amount_in;
      rq_ff         <= rq_in;
      mx_ff         <= mx_in;
      status_ff     <= status_in;
      spare_ff      <= spare_in;
      cap_ff        <= cap_in;
      parts_ff      <= parts_in;
      give_ff       <= give_in;
      given_ff      <= given_in;
      idx_ff        <= idx_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_pool_ff   <= rsp_pool_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.kind       = rsp_kind_ff;
   assign rsp_ch.pool_index = rsp_pool_ff;
   assign rsp_ch.value      = rsp_value_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.last       = rsp_last_ff;

   // a budget beat is never final and always ok; a final beat is a status beat
   a_budget_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.kind == KIND_BUDGET |->
         rsp_ch.status == ST_OK && !rsp_ch.last)
      else $error("malformed budget beat");

   a_last_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.last |-> rsp_ch.kind == KIND_STATUS)
      else $error("final beat is not a status beat");

   // cumulative parts never pass the summed capacity, nor the quotient the amount to give
   a_parts_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PEMIT |-> parts_ff <= cap_ff && md_quot <= give_ff)
      else $error("share walk out of bounds");

endmodule

// ----- test/pmba_checker.sv -----
// Checker: predicts the allocator's result beats from observed commands and compares them.
module pmba_checker
   import pmba_pkg::*;
#(
   parameter int MAX_POOLS = 16
) (
   input  logic              clock,
   input  logic              reset,
   pmba_req_if               req_mon,
   pmba_rsp_if               rsp_mon,
   input  logic              csr_write_en,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [BYTE_W-1:0] csr_write_data,
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              kind;
      logic [SLOT_W-1:0] pool_index;
      logic [BYTE_W-1:0] value;
      logic [STAT_W-1:0] status;
      logic              last;
   } beat_type;

   // predicted beats, oldest first
   beat_type beat_q[$];

   // shadow of the configuration and pool table
   logic [SEG_W-1:0]  seg_size;
   logic [BYTE_W-1:0] total_mem;
   logic              disabled;
   logic              pool_live   [MAX_POOLS];
   logic [BYTE_W-1:0] pool_req    [MAX_POOLS];
   logic [BYTE_W-1:0] pool_max    [MAX_POOLS];
   logic [BYTE_W-1:0] pool_budget [MAX_POOLS];
   logic [BYTE_W-1:0] reserved, avail, used;

   function automatic logic [BYTE_W-1:0] sat36(logic [63:0] v);
      return (v > 64'(BYTE_MAX)) ? BYTE_MAX : v[BYTE_W-1:0];
   endfunction

   function automatic logic [63:0] floor0(logic [63:0] a, logic [63:0] b);
      return (a > b) ? a - b : 64'd0;
   endfunction

   function automatic logic [BYTE_W-1:0] sub36(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

   task automatic post_budget(int i, logic [63:0] b);
      beat_type item;
      pool_budget[i] = sat36(b);
      item = '{KIND_BUDGET, SLOT_W'(i), pool_budget[i], ST_OK, 1'b0};
      beat_q = {beat_q, item};
   endtask

   // share the unreserved memory among live pools by cumulative division
   task automatic share_spare();
      logic [63:0] spare, cap, give, parts, given, e, q, share;
      spare = floor0(64'(total_mem), 64'(reserved));
      if (spare == 0) begin
         for (int i = 0; i < MAX_POOLS; i++)
            if (pool_live[i]) post_budget(i, 64'(pool_req[i]));
         return;
      end
      cap = 0;
      for (int i = 0; i < MAX_POOLS; i++) begin
         if (!pool_live[i]) continue;
         e = floor0(64'(pool_max[i]), 64'(pool_req[i]));
         cap += (e < spare) ? e : spare;
      end
      if (cap == 0) return;
      give = (spare < cap) ? spare : cap;
      parts = 0;
      given = 0;
      for (int i = 0; i < MAX_POOLS; i++) begin
         if (!pool_live[i]) continue;
         e = floor0(64'(pool_max[i]), 64'(pool_req[i]));
         if (e == 0) continue;
         parts += (e < spare) ? e : spare;
         q = 64'((128'(give) * 128'(parts)) / 128'(cap));
         share = floor0(q, given);
         given += share;
         post_budget(i, 64'(pool_req[i]) + share);
      end
   endtask

   task automatic run_command(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                              logic [BUF_W-1:0] rqb, logic [BUF_W-1:0] mxb,
                              logic [BYTE_W-1:0] amt);
      logic [STAT_W-1:0] st;
      logic [BYTE_W-1:0] rq;
      beat_type          item;
      st = ST_OK;
      case (cmd)
         CMD_REGISTER: begin
            rq = sat36(64'(rqb) * 64'(seg_size));
            if (disabled) st = ST_DISABLED;
            else if (int'(slot) >= MAX_POOLS || pool_live[slot]) st = ST_BUSY;
            else if (64'(reserved) + 64'(rq) > 64'(total_mem)) st = ST_NOMEM;
            else begin
               reserved = sat36(64'(reserved) + 64'(rq));
               avail = sub36(avail, rq);
               used = sat36(64'(used) + 64'(rq));
               pool_live[slot] = 1'b1;
               pool_req[slot] = rq;
               pool_max[slot] = sat36(64'(mxb) * 64'(seg_size));
               pool_budget[slot] = rq;
               share_spare();
            end
         end
         CMD_UNREGISTER: begin
            if (int'(slot) >= MAX_POOLS) st = ST_BUSY;
            else if (pool_live[slot]) begin
               pool_live[slot] = 1'b0;
               reserved = sub36(reserved, pool_req[slot]);
               share_spare();
            end
         end
         CMD_RESERVE: begin
            if (64'(reserved) + 64'(amt) > 64'(total_mem)) st = ST_NOMEM;
            else begin
               reserved = sat36(64'(reserved) + 64'(amt));
               share_spare();
            end
         end
         CMD_REQUEST: begin
            if (disabled) st = ST_DISABLED;
            else if (avail == 0 || avail < amt) st = ST_NOMEM;
            else begin
               avail = avail - amt;
               used = sat36(64'(used) + 64'(amt));
            end
         end
         CMD_RETURN: begin
            avail = sat36(64'(avail) + 64'(amt));
            used = sub36(used, amt);
         end
         default: ;
      endcase
      item = '{KIND_STATUS, slot, avail, st, 1'b1};
      beat_q = {beat_q, item};
   endtask

   always @(posedge clock) begin : monitor
      beat_type got, want;
      if (reset) begin
         fail_count = 0;
         seg_size = SEG_RESET;
         total_mem = TOTAL_RESET;
         disabled = 1'b0;
         for (int i = 0; i < MAX_POOLS; i++) pool_live[i] = 1'b0;
         reserved = '0;
         avail = TOTAL_RESET;
         used = '0;
         beat_q.delete();
      end else begin
         // register writes
         if (csr_write_en) begin
            case (csr_index)
               CSR_SEGMENT_SIZE: seg_size = csr_write_data[SEG_W-1:0];
               CSR_TOTAL_MEMORY: total_mem = csr_write_data;
               CSR_DISABLED:     disabled = csr_write_data[0];
               default: ;
            endcase
         end
         // result beat against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.kind, rsp_mon.pool_index, rsp_mon.value, rsp_mon.status,
                    rsp_mon.last};
            if (beat_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result beat %p", $time, got);
            end else begin
               want = beat_q[0];
               beat_q.delete(0);
               if (got.kind !== want.kind) begin
                  fail_count++;
                  $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
               end
               if (got.pool_index !== want.pool_index) begin
                  fail_count++;
                  $display("%0t: pool_index expected %0d actual %0d", $time,
                           want.pool_index, got.pool_index);
               end
               if (got.value !== want.value) begin
                  fail_count++;
                  $display("%0t: value expected %0d actual %0d", $time, want.value,
                           got.value);
               end
               if (got.status !== want.status) begin
                  fail_count++;
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           got.status);
               end
               if (got.last !== want.last) begin
                  fail_count++;
                  $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
               end
            end
         end
         // command beat
         if (req_mon.valid && req_mon.ready)
            run_command(req_mon.command, req_mon.slot, req_mon.required_buffers,
                        req_mon.max_buffers, req_mon.amount);
      end
      pending = beat_q.size();
   end

endmodule

// ----- test/tb_proportional_memory_budget_allocator.sv -----
// Testbench top: clock, reset, command stimulus, result back-pressure and verdict.
module tb_proportional_memory_budget_allocator;
   import pmba_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GAP_MAX  = 12;
   localparam int HOLD_OFF = 400;
   localparam int STUCK_MAX = 20000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_en = 1'b0;
   logic [CSR_W-1:0]  csr_index = CSR_SEGMENT_SIZE;
   logic [BYTE_W-1:0] csr_write_data = '0;
   int                fail_count, pending;
   bit                no_idle = 1'b0;
   bit                hold_rsp = 1'b0;
   int                stuck = 0;

   pmba_req_if req_ch ();
   pmba_rsp_if rsp_ch ();

   proportional_memory_budget_allocator dut (
      .clock, .reset, .req_ch, .rsp_ch, .csr_write_en, .csr_index, .csr_write_data
   );

   pmba_checker chk (
      .clock, .reset, .req_mon(req_ch), .rsp_mon(rsp_ch), .csr_write_en, .csr_index,
      .csr_write_data, .fail_count, .pending
   );

   always #2 clock = ~clock;

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   // one command beat; returns at the accepting edge
   task automatic send(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                       logic [BUF_W-1:0] rqb, logic [BUF_W-1:0] mxb,
                       logic [BYTE_W-1:0] amt);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.slot <= slot;
      req_ch.required_buffers <= rqb;
      req_ch.max_buffers <= mxb;
      req_ch.amount <= amt;
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
   endtask

   // wait until every predicted beat has arrived and the block is quiet
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_W-1:0] idx, logic [BYTE_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] rand36();
      return {4'($urandom_range(0, 15)), $urandom()};
   endfunction

   // mostly well-formed commands with moderate sizes, some noise
   task automatic random_command();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         send(CMD_REGISTER, SLOT_W'($urandom_range(0, 15)),
              BUF_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 200)),
              BUF_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 1000)),
              rand36());
      else if (pick < 45)
         send(CMD_UNREGISTER, SLOT_W'($urandom_range(0, 15)), BUF_W'($urandom()),
              BUF_W'($urandom()), rand36());
      else if (pick < 55)
         send(CMD_RESERVE, SLOT_W'($urandom_range(0, 15)), BUF_W'($urandom()),
              BUF_W'($urandom()),
              ($urandom_range(0, 4) == 0) ? rand36() : BYTE_W'($urandom_range(0, 1 << 20)));
      else if (pick < 75)
         send(CMD_REQUEST, SLOT_W'($urandom_range(0, 15)), BUF_W'($urandom()),
              BUF_W'($urandom()),
              ($urandom_range(0, 4) == 0) ? rand36() : BYTE_W'($urandom_range(0, 1 << 24)));
      else if (pick < 92)
         send(CMD_RETURN, SLOT_W'($urandom_range(0, 15)), BUF_W'($urandom()),
              BUF_W'($urandom()),
              ($urandom_range(0, 9) == 0) ? rand36() : BYTE_W'($urandom_range(0, 1 << 24)));
      else
         send(CMD_W'($urandom_range(0, 7)), SLOT_W'($urandom_range(0, 15)),
              BUF_W'($urandom()), BUF_W'($urandom()), rand36());
   endtask

   // result side: random stalls and one long hold-off
   initial begin : rsp_side
      int stall;
      bit held;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp && !held) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
         end
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(negedge clock); while (!rsp_ch.valid);
         @(posedge clock);
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) stuck <= 0;
      else stuck <= stuck + 1;
      if (stuck >= STUCK_MAX) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      req_ch.valid = 1'b0;
      req_ch.command = CMD_REQUEST;
      req_ch.slot = '0;
      req_ch.required_buffers = '0;
      req_ch.max_buffers = '0;
      req_ch.amount = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty and saturated available bytes
      send(CMD_REQUEST, 4'd0, '0, '0, 36'd67108864);
      send(CMD_REQUEST, 4'd0, '0, '0, '0);
      send(CMD_REQUEST, 4'd0, '0, '0, 36'd1);
      send(CMD_RETURN, 4'd15, '0, '0, BYTE_MAX);
      send(CMD_REQUEST, 4'd0, '0, '0, BYTE_MAX);
      send(CMD_RETURN, 4'd0, '0, '0, 36'd67108864);
      // directed: registration cases
      send(CMD_REGISTER, 4'd0, 16'd0, 16'd0, '0);
      send(CMD_REGISTER, 4'd1, 16'd10, 16'd100, '0);
      send(CMD_REGISTER, 4'd15, 16'd100, 16'd50, '0);
      send(CMD_REGISTER, 4'd1, 16'd1, 16'd2, '0);
      send(CMD_REGISTER, 4'd2, 16'hFFFF, 16'hFFFF, '0);
      send(CMD_REGISTER, 4'd3, 16'd5, 16'hFFFF, '0);
      send(CMD_RESERVE, 4'd0, '0, '0, 36'd1048576);
      send(CMD_RESERVE, 4'd0, '0, '0, BYTE_MAX);
      send(CMD_UNREGISTER, 4'd7, '0, '0, '0);
      send(CMD_UNREGISTER, 4'd1, '0, '0, '0);
      // codes above the last defined command
      for (int c = int'(CMD_RETURN) + 1; c < (1 << CMD_W); c++)
         send(CMD_W'(c), 4'd15, 16'hFFFF, 16'hFFFF, BYTE_MAX);
      send(CMD_REQUEST, 4'd0, '0, '0, '0);
      drain();

      // random phases, each under its own configuration
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_SEGMENT_SIZE, 36'd1);
               write_csr(CSR_TOTAL_MEMORY, BYTE_MAX);
            end
            1: begin
               write_csr(CSR_SEGMENT_SIZE, 36'd1048576);
               write_csr(CSR_TOTAL_MEMORY, 36'd1 << 30);
            end
            2: write_csr(CSR_TOTAL_MEMORY, '0);
            3: begin
               write_csr(CSR_DISABLED, 36'd1);
               write_csr(CSR_TOTAL_MEMORY, 36'd67108864);
            end
            4: begin
               write_csr(CSR_DISABLED, '0);
               write_csr(CSR_SEGMENT_SIZE, 36'($urandom_range(1, 4096)));
               write_csr(CSR_TOTAL_MEMORY, 36'($urandom_range(1 << 20, 1 << 28)));
            end
            default: begin
               write_csr(CSR_SEGMENT_SIZE, 36'd32768);
               write_csr(CSR_TOTAL_MEMORY, 36'd67108864);
            end
         endcase
         no_idle = (phase == 2);
         for (int n = 0; n < 55; n++) begin
            if (phase == 1 && n == 20) hold_rsp = 1'b1;
            random_command();
         end
         drain();
      end

      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
